// ===== hdl/mandelbrot_escape_time_macros.svh =====
// Assertion macros for the escape-time block.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent checked in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Consequent checked in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define MET_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/met_pkg.sv =====
`timescale 1ns / 1ps

package met_pkg;

	localparam int DATA_W         = 32;
	localparam int CFG_W          = 12;
	localparam int CNT_OUT_W      = 12;
	localparam int FRAC_BITS_DEF  = 28;
	localparam int COUNT_BITS_DEF = 12;
	localparam logic [CFG_W-1:0] MAX_ITER_RESET = 12'd200;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

	// One request as it travels from the front to the iteration engine.
	typedef struct packed {
		logic signed [DATA_W-1:0] c_re;
		logic signed [DATA_W-1:0] c_im;
		logic                     last_pixel;
		logic                     skip;
	} met_job_t;

	typedef struct packed {
		logic [QUEUE_LW-1:0] level;
		logic                full;
		logic                empty;
	} met_q_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} met_back_stat_t;

	// Clamp a wide signed value to the coordinate range.
	function automatic logic signed [DATA_W-1:0] sat_coord(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2147483647;
		lo = -64'sd2147483648;
		if (v > hi) begin
			sat_coord = DATA_W'(hi);
		end else if (v < lo) begin
			sat_coord = DATA_W'(lo);
		end else begin
			sat_coord = DATA_W'(v);
		end
	endfunction

endpackage

// ===== hdl/met_pt_if.sv =====
`timescale 1ns / 1ps

interface met_pt_if;
	import met_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] c_re;
	logic signed [DATA_W-1:0] c_im;
	logic                     last_pixel;

	modport source (output valid, output c_re, output c_im, output last_pixel, input ready);
	modport sink (input valid, input c_re, input c_im, input last_pixel, output ready);
endinterface

// ===== hdl/met_res_if.sv =====
`timescale 1ns / 1ps

interface met_res_if;
	import met_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CNT_OUT_W-1:0] escape_count;
	logic                 frame_end;

	modport source (output valid, output escape_count, output frame_end, input ready);
	modport sink (input valid, input escape_count, input frame_end, output ready);
endinterface

// ===== hdl/mandelbrot_escape_time.sv =====
// Points pass the front register and a two-entry queue, which keeps the input side
// taking points, to the shared iteration engine. Each step there is a multiply state
// then an update state; the engine takes a point only after the last result is out.
// Reset (arst_n, asynchronous, active low) empties the front, queue and output
// register and sets the limit to 200; no clearing pass.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time #(
	parameter int FRAC_BITS  = met_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = met_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [met_pkg::CFG_W-1:0] cfg_wdata,
	met_pt_if.sink                    points,
	met_res_if.source                 results
);
	import met_pkg::*;

	logic [CFG_W-1:0]      max_iter_q;
	logic [COUNT_BITS-1:0] count_limit;

	logic           f_valid;
	logic           f_ready;
	met_job_t       f_job;
	logic           q_valid;
	logic           q_ready;
	met_job_t       q_job;
	met_q_stat_t    q_stat;
	met_back_stat_t b_stat;
	logic           push;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
		end else if (cfg_we) begin
			max_iter_q <= cfg_wdata;
		end
	end

	// Only the low COUNT_BITS bits of the register set the limit.
	assign count_limit = COUNT_BITS'(max_iter_q);

	assign push = f_valid && f_ready;
	assign pop  = q_valid && q_ready;

	met_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pt          (points),
		.count_limit (count_limit),
		.job_valid   (f_valid),
		.job_ready   (f_ready),
		.job         (f_job)
	);

	met_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_job    (f_job),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_job   (q_job),
		.stat      (q_stat)
	);

	met_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.count_limit (count_limit),
		.job_valid   (q_valid),
		.job_ready   (q_ready),
		.job         (q_job),
		.res         (results),
		.stat        (b_stat)
	);

	`MET_ASSERT_NEXT(a_level_up, clk, arst_n, push && !pop, q_stat.level == $past(q_stat.level) + 1'b1)
	`MET_ASSERT_SAME(a_no_pop_empty, clk, arst_n, q_stat.empty, !pop)
	`MET_ASSERT_NEXT(a_pop_busy, clk, arst_n, pop, b_stat.busy)
	`MET_ASSERT_SAME(a_done_no_pop, clk, arst_n, b_stat.done, !pop)

endmodule

// ===== hdl/met_front.sv =====
`timescale 1ns / 1ps

module met_front #(
	parameter int COUNT_BITS = met_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	met_pt_if.sink                pt,
	input  logic [COUNT_BITS-1:0] count_limit,
	output logic                  job_valid,
	input  logic                  job_ready,
	output met_pkg::met_job_t     job
);
	import met_pkg::*;

	logic     valid_s1;
	met_job_t job_s1;
	logic     take;

	assign pt.ready  = !valid_s1 || job_ready;
	assign take      = pt.valid && pt.ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// A zero limit needs no iteration: mark it so the engine answers at once.
	always_ff @(posedge clk) begin
		if (take) begin
			job_s1.c_re       <= pt.c_re;
			job_s1.c_im       <= pt.c_im;
			job_s1.last_pixel <= pt.last_pixel;
			job_s1.skip       <= (count_limit == '0);
		end
	end

endmodule

// ===== hdl/met_queue.sv =====
`timescale 1ns / 1ps

module met_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  met_pkg::met_job_t     in_job,
	output logic                  out_valid,
	input  logic                  out_ready,
	output met_pkg::met_job_t     out_job,
	output met_pkg::met_q_stat_t  stat
);
	import met_pkg::*;

	met_job_t            entry_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_LW-1:0] level_q;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	assign full      = (level_q == QUEUE_LW'(QUEUE_DEPTH));
	assign empty     = (level_q == '0);
	assign in_ready  = !full;
	assign out_valid = !empty;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_job   = entry_q[rd_ptr_q];

	assign stat.level = level_q;
	assign stat.full  = full;
	assign stat.empty = empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

// ===== hdl/met_back.sv =====
`timescale 1ns / 1ps

module met_back #(
	parameter int FRAC_BITS  = met_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = met_pkg::COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [COUNT_BITS-1:0]    count_limit,
	input  logic                     job_valid,
	output logic                     job_ready,
	input  met_pkg::met_job_t        job,
	met_res_if.source                res,
	output met_pkg::met_back_stat_t  stat
);
	import met_pkg::*;

	localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_STEP = 4'b0100,
		ST_DONE = 4'b1000
	} met_state_t;

	met_state_t state_q;

	logic signed [DATA_W-1:0] c_re_q;
	logic signed [DATA_W-1:0] c_im_q;
	logic signed [DATA_W-1:0] z_re_q;
	logic signed [DATA_W-1:0] z_im_q;
	logic signed [63:0]       rr_q;
	logic signed [63:0]       ii_q;
	logic signed [63:0]       ri_q;
	logic                     last_q;
	logic [COUNT_BITS-1:0]    count_q;
	logic [COUNT_BITS-1:0]    result_q;

	logic                     res_valid_q;
	logic [CNT_OUT_W-1:0]     escape_q;
	logic                     frame_q;

	logic [63:0]              sq_sum;
	logic                     in_disc;
	logic                     go_on;
	logic signed [63:0]       diff;
	logic signed [63:0]       re_wide;
	logic signed [63:0]       im_wide;
	logic                     pop;
	logic                     out_free;

	assign job_ready = (state_q == ST_IDLE);
	assign pop       = job_valid && job_ready;
	assign out_free  = !res_valid_q || res.ready;

	// Escape test on the squares of the current z; shifts past the width give zero.
	assign sq_sum  = $unsigned(rr_q) + $unsigned(ii_q);
	assign in_disc = ((sq_sum >> ESC_SHIFT) == 64'd0);
	assign go_on   = (count_q < count_limit) && in_disc;

	assign diff    = rr_q - ii_q;
	assign re_wide = (diff >>> FRAC_BITS) + 64'(c_re_q);
	assign im_wide = (ri_q >>> (FRAC_BITS - 1)) + 64'(c_im_q);

	assign res.valid        = res_valid_q;
	assign res.escape_count = escape_q;
	assign res.frame_end    = frame_q;

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= job.skip ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					state_q <= go_on ? ST_MUL : ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					c_re_q   <= job.c_re;
					c_im_q   <= job.c_im;
					last_q   <= job.last_pixel;
					z_re_q   <= '0;
					z_im_q   <= '0;
					count_q  <= '0;
					result_q <= '0;
				end
			end
			ST_MUL: begin
				rr_q <= z_re_q * z_re_q;
				ii_q <= z_im_q * z_im_q;
				ri_q <= z_re_q * z_im_q;
			end
			ST_STEP: begin
				if (go_on) begin
					z_re_q  <= sat_coord(re_wide);
					z_im_q  <= sat_coord(im_wide);
					count_q <= count_q + 1'b1;
				end else begin
					// Reaching the limit reports the point as inside the set.
					result_q <= (count_q == count_limit) ? '0 : count_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					escape_q <= CNT_OUT_W'(result_q);
					frame_q  <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import met_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint unsigned ESC_BOUND = 64'd1 << (2 * FRAC + 2);
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
		logic                     last;
	} point_t;

	typedef struct {
		logic [CNT_OUT_W-1:0] count;
		logic                 frame_end;
	} escape_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	met_pt_if  pt_bus ();
	met_res_if res_bus ();

	mandelbrot_escape_time u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.points    (pt_bus),
		.results   (res_bus)
	);

	escape_result_t pending_counts[$];
	logic [CFG_W-1:0] iter_limit = MAX_ITER_RESET;
	int idle_pct = 30;
	int error_count = 0;
	int points_sent = 0;
	int results_seen = 0;
	int limits_used = 1;
	int deepest_count = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	always #1 clk = ~clk;

	function automatic longint clamp_coord(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Iterate z = z*z + c from the origin; 0 when the limit is reached.
	function automatic logic [CNT_OUT_W-1:0] escape_steps(input logic signed [DATA_W-1:0] cr,
			input logic signed [DATA_W-1:0] ci, input logic [CFG_W-1:0] lim);
		longint zr, zi, sq_r, sq_i, nr, ni, cr64, ci64;
		longint unsigned mag;
		int n;
		zr = 0;
		zi = 0;
		n = 0;
		cr64 = longint'(cr);
		ci64 = longint'(ci);
		while (n < lim) begin
			sq_r = zr * zr;
			sq_i = zi * zi;
			mag = sq_r + sq_i;
			if (mag >= ESC_BOUND)
				break;
			nr = clamp_coord(((sq_r - sq_i) >>> FRAC) + cr64);
			ni = clamp_coord(((zr * zi) >>> (FRAC - 1)) + ci64);
			zr = nr;
			zi = ni;
			n++;
		end
		if (n == lim)
			n = 0;
		return CNT_OUT_W'(n);
	endfunction

	function automatic logic signed [DATA_W-1:0] to_fx(input real r);
		return DATA_W'($rtoi(r * 268435456.0));
	endfunction

	function automatic int idle_len(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(12, 48);
		return $urandom_range(1, 3);
	endfunction

	function automatic point_t random_point();
		point_t p;
		if ($urandom_range(0, 4) == 0) begin
			p.re = $urandom;
			p.im = $urandom;
		end else begin
			// Window around the set: re in [-2.25, 0.75), im in [-1.5, 1.5)
			p.re = -(9 <<< 26) + $urandom_range(0, 3 * (1 << FRAC) - 1);
			p.im = -(3 <<< 27) + $urandom_range(0, 3 * (1 << FRAC) - 1);
		end
		p.last = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	task automatic send_point(input point_t p);
		escape_result_t exp_r;
		int gap;
		gap = idle_len(idle_pct);
		repeat (gap) begin
			@(negedge clk);
			pt_bus.valid = 1'b0;
		end
		@(negedge clk);
		pt_bus.valid = 1'b1;
		pt_bus.c_re = p.re;
		pt_bus.c_im = p.im;
		pt_bus.last_pixel = p.last;
		do
			@(posedge clk);
		while (!pt_bus.ready);
		exp_r.count = escape_steps(p.re, p.im, iter_limit);
		exp_r.frame_end = p.last;
		if (exp_r.count > deepest_count)
			deepest_count = exp_r.count;
		pending_counts.push_back(exp_r);
		points_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		pt_bus.valid = 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] v);
		drain_results();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		iter_limit = v;
		limits_used++;
	endtask

	task automatic send_xy(input real re, input real im, input logic last);
		point_t p;
		p.re = to_fx(re);
		p.im = to_fx(im);
		p.last = last;
		send_point(p);
	endtask

	task automatic send_raw(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
			input logic last);
		point_t p;
		p.re = re;
		p.im = im;
		p.last = last;
		send_point(p);
	endtask

	// Limit from reset, coordinate extremes, escape on the boundary value of 4.
	task automatic test_reset_limit();
		send_xy(0.0, 0.0, 1'b0);
		send_xy(-2.0, 0.0, 1'b0);
		send_xy(2.0, 0.0, 1'b1);
		send_raw(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_raw(32'h8000_0000, 32'h8000_0000, 1'b1);
		send_raw(32'h8000_0000, 32'h7fff_ffff, 1'b0);
		send_raw(32'h0000_0001, 32'hffff_ffff, 1'b0);
		send_xy(0.25, 0.0, 1'b0);
		send_xy(-1.0, 0.0, 1'b0);
		send_xy(0.0, 1.0, 1'b0);
		send_xy(0.0, -1.0, 1'b0);
		send_xy(-0.75, 0.1, 1'b0);
		send_xy(0.3, 0.5, 1'b0);
		send_xy(1.0, 0.0, 1'b1);
	endtask

	task automatic test_limit_extremes();
		// Every point stops after its single step and so reads as inside
		write_limit(12'd1);
		send_xy(0.0, 0.0, 1'b0);
		send_raw(32'h7fff_ffff, 32'h8000_0000, 1'b1);
		send_xy(-0.5, 0.5, 1'b0);
		write_limit(12'hfff);
		send_xy(-0.75, 0.01, 1'b0);
		send_xy(0.2501, 0.0, 1'b0);
		send_xy(0.25 + 1.0 / 1048576.0, 0.0, 1'b0);
		send_xy(0.0, 0.0, 1'b1);
		// Limit zero: the loop never runs
		write_limit(12'd0);
		send_xy(0.0, 0.0, 1'b0);
		send_raw(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
	endtask

	task automatic test_random_points(input int n_items, input logic [CFG_W-1:0] lim,
			input int pct);
		write_limit(lim);
		idle_pct = pct;
		repeat (n_items)
			send_point(random_point());
	endtask

	// Hold the result side off while requests keep coming, so the input stalls.
	task automatic test_output_stall();
		write_limit(12'd32);
		idle_pct = 0;
		@(posedge clk);
		hold_req = 1'b1;
		repeat (24)
			send_point(random_point());
		idle_pct = 30;
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			res_bus.ready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			res_bus.ready = 1'b0;
			stall_left--;
		end else begin
			stall_left = idle_len(idle_pct);
			if (stall_left > 0) begin
				res_bus.ready = 1'b0;
				stall_left--;
			end else begin
				res_bus.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		escape_result_t exp_r;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen++;
			if (pending_counts.size() == 0) begin
				$error("result with no point outstanding: escape_count %0d",
					res_bus.escape_count);
				error_count++;
			end else begin
				exp_r = pending_counts.pop_front();
				if (res_bus.escape_count !== exp_r.count) begin
					$error("escape_count mismatch: expected %0d, got %0d",
						exp_r.count, res_bus.escape_count);
					error_count++;
				end
				if (res_bus.frame_end !== exp_r.frame_end) begin
					$error("frame_end mismatch: expected %0d, got %0d",
						exp_r.frame_end, res_bus.frame_end);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pt_bus.valid = 1'b0;
		pt_bus.c_re = '0;
		pt_bus.c_im = '0;
		pt_bus.last_pixel = 1'b0;
		res_bus.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_limit();
		test_limit_extremes();
		test_random_points(130, 12'd64, 30);
		test_random_points(110, CFG_W'($urandom_range(2, 300)), 30);
		test_random_points(110, CFG_W'($urandom_range(2, 300)), 0);
		test_random_points(110, CFG_W'($urandom_range(2, 20)), 50);
		test_output_stall();
		test_random_points(12, 12'hfff, 30);
		test_random_points(100, CFG_W'($urandom_range(100, 300)), 20);

		drain_results();
		repeat (20) @(posedge clk);
		if (pending_counts.size() != 0) begin
			$error("%0d results never arrived", pending_counts.size());
			error_count++;
		end
		$display("Sent %0d points under %0d iteration limits; checked %0d results.",
			points_sent, limits_used, results_seen);
		$display("Deepest escape count %0d; output held off for %0d cycles once.",
			deepest_count, HOLD_CYCLES);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("Timeout with %0d results outstanding", pending_counts.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/met_pkg.sv
hdl/met_pt_if.sv
hdl/met_res_if.sv
hdl/met_front.sv
hdl/met_queue.sv
hdl/met_back.sv
hdl/mandelbrot_escape_time.sv
tb/tb_top.sv
